// ===== rtl/core/tcc_pkg.sv =====
// Package for the text console with cursor and scroll.
// Holds default geometry, character codes, sequencer states and request/result types.
// No dependencies.
package tcc_pkg;

  // Default geometry of the character map.
  localparam int ROWS_DEF         = 20;
  localparam int VISIBLE_COLS_DEF = 30;
  localparam int MAP_COLS_DEF     = 32;

  // Character codes with special meaning.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Request action codes.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL
  } state_t;

  // One request.
  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [4:0] read_col;
  } req_t;

  // One result.
  typedef struct packed {
    logic [7:0] cell_value;
    logic [4:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } rsp_t;

endpackage

// ===== rtl/core/tcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tcc_addr_unit.sv =====
// Shared address unit: maps a logical row and column to a map address.
// The logical row is rotated by the scroll base, modulo the row count.
// Depends on nothing outside its parameters.
module tcc_addr_unit #(
  parameter int ROWS     = 20,
  parameter int MAP_COLS = 32,
  localparam int RW  = $clog2(ROWS),
  localparam int MCW = $clog2(MAP_COLS),
  localparam int AW  = $clog2(ROWS * MAP_COLS)
) (
  input  logic [RW-1:0]  row,
  input  logic [MCW-1:0] col,
  input  logic [RW-1:0]  base,
  output logic [AW-1:0]  addr
);

  localparam logic [RW:0]   ROWS_W     = (RW+1)'(ROWS);
  localparam logic [AW-1:0] MAP_COLS_A = AW'(MAP_COLS);

  logic [RW:0]   phys_sum;
  logic [RW-1:0] phys_row;

  always_comb begin
    phys_sum = {1'b0, row} + {1'b0, base};
    if (phys_sum >= ROWS_W) begin
      phys_sum = phys_sum - ROWS_W;
    end
    phys_row = phys_sum[RW-1:0];
    addr     = AW'(phys_row) * MAP_COLS_A + AW'(col);
  end

endmodule

// ===== rtl/core/text_console_cursor_scroll_top.sv =====
// Text console with cursor and scroll: a put request or an out-of-range read raises the
// result strobe from the done register after the execute state, an in-range read after the
// read state (registered map read), and a put that scrolls after the scroll state, which
// makes one map write per bottom-row cell. A new request is taken only in the idle state.
// After reset the map is swept to spaces, all ROWS*MAP_COLS cells (640 by default), busy high.
// Depends on tcc_pkg, tcc_ram and tcc_addr_unit.
module text_console_cursor_scroll_top #(
  parameter int ROWS         = tcc_pkg::ROWS_DEF,
  parameter int VISIBLE_COLS = tcc_pkg::VISIBLE_COLS_DEF,
  parameter int MAP_COLS     = tcc_pkg::MAP_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tcc_pkg::req_t request,
  output logic          done,
  output tcc_pkg::rsp_t result
);

  // Widths follow from the geometry.
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(VISIBLE_COLS);
  localparam int MCW   = $clog2(MAP_COLS);
  localparam int DEPTH = ROWS * MAP_COLS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0]  LAST_VCOL = CW'(VISIBLE_COLS - 1);
  localparam logic [MCW-1:0] LAST_MCOL = MCW'(MAP_COLS - 1);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [6:0]     ROWS_L    = 7'(ROWS);
  localparam logic [6:0]     MCOLS_L   = 7'(MAP_COLS);

  // Sequencer and control registers.
  tcc_pkg::state_t state, state_next;
  logic [AW-1:0]   init_addr;
  logic [MCW-1:0]  clr_col;
  logic [RW-1:0]   base;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic            done_next;

  // Payload registers.
  tcc_pkg::req_t   req;
  tcc_pkg::rsp_t   result_next;

  // Decode of the latched request against the current cursor.
  logic            is_read;
  logic            in_range;
  logic            need_scroll;
  logic            do_write;
  logic [CW-1:0]   col_after;
  logic [RW-1:0]   row_after;
  logic            clr_last;

  // Address unit operands and map port.
  logic [RW-1:0]   au_row;
  logic [MCW-1:0]  au_col;
  logic [AW-1:0]   au_addr;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  // Width adapters: request fields to internal widths and cursor to the 5-bit result fields.
  logic [RW+4:0]   rd_row_x;
  logic [MCW+4:0]  rd_col_x;
  logic [CW+MCW-1:0] cur_col_x;
  logic [CW+4:0]   cur_col5_x;
  logic [CW+4:0]   col_after5_x;
  logic [RW+4:0]   cur_row5_x;
  logic [RW+4:0]   row_after5_x;

  assign rd_row_x     = {{RW{1'b0}}, req.read_row};
  assign rd_col_x     = {{MCW{1'b0}}, req.read_col};
  assign cur_col_x    = {{MCW{1'b0}}, cur_col};
  assign cur_col5_x   = {5'b0, cur_col};
  assign col_after5_x = {5'b0, col_after};
  assign cur_row5_x   = {5'b0, cur_row};
  assign row_after5_x = {5'b0, row_after};

  // The block is free only in the idle state; the reset sweep counts as busy.
  assign busy     = (state != tcc_pkg::ST_IDLE);
  assign clr_last = (clr_col == LAST_MCOL);

  // Request decode. A printable byte is stored only where the cursor lies inside the
  // map width; advancing past the last visible column, or a newline, moves to the next
  // row, and on the last row that becomes a scroll with the cursor held on the last row.
  always_comb begin
    is_read     = (req.action == tcc_pkg::ACT_READ);
    in_range    = ({2'b0, req.read_row} < ROWS_L) && ({2'b0, req.read_col} < MCOLS_L);
    col_after   = cur_col;
    row_after   = cur_row;
    need_scroll = 1'b0;
    do_write    = 1'b0;
    if (!is_read) begin
      case (req.char_code)
        tcc_pkg::CH_NUL: begin
        end
        tcc_pkg::CH_NEWLINE: begin
          col_after = '0;
          if (cur_row == LAST_ROW) begin
            need_scroll = 1'b1;
          end else begin
            row_after = cur_row + 1'b1;
          end
        end
        tcc_pkg::CH_RETURN: begin
          col_after = '0;
        end
        tcc_pkg::CH_BACKSPACE: begin
          if (cur_col != '0) begin
            col_after = cur_col - 1'b1;
          end
        end
        default: begin
          do_write = (int'(cur_col) < MAP_COLS);
          if (cur_col == LAST_VCOL) begin
            col_after = '0;
            if (cur_row == LAST_ROW) begin
              need_scroll = 1'b1;
            end else begin
              row_after = cur_row + 1'b1;
            end
          end else begin
            col_after = cur_col + 1'b1;
          end
        end
      endcase
    end
  end

  // Operands of the shared address unit. During a scroll it walks logical row 0, which
  // is the physical row that becomes the new bottom row once the base advances.
  always_comb begin
    if (state == tcc_pkg::ST_SCROLL) begin
      au_row = '0;
      au_col = clr_col;
    end else if (is_read) begin
      au_row = rd_row_x[RW-1:0];
      au_col = rd_col_x[MCW-1:0];
    end else begin
      au_row = cur_row;
      au_col = cur_col_x[MCW-1:0];
    end
  end

  tcc_addr_unit #(
    .ROWS     (ROWS),
    .MAP_COLS (MAP_COLS)
  ) u_addr (
    .row  (au_row),
    .col  (au_col),
    .base (base),
    .addr (au_addr)
  );

  tcc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (au_addr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tcc_pkg::ST_INIT: begin
        if (init_addr == LAST_ADDR) begin
          state_next = tcc_pkg::ST_IDLE;
        end
      end
      tcc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tcc_pkg::ST_EXEC;
        end
      end
      tcc_pkg::ST_EXEC: begin
        if (is_read) begin
          state_next = in_range ? tcc_pkg::ST_READ : tcc_pkg::ST_IDLE;
        end else if (need_scroll) begin
          state_next = tcc_pkg::ST_SCROLL;
        end else begin
          state_next = tcc_pkg::ST_IDLE;
        end
      end
      tcc_pkg::ST_READ: begin
        state_next = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_SCROLL: begin
        if (clr_last) begin
          state_next = tcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: map port controls and the next result.
  always_comb begin
    done_next   = 1'b0;
    result_next = result;
    ram_we      = 1'b0;
    ram_waddr   = au_addr;
    ram_wdata   = tcc_pkg::CH_SPACE;
    case (state)
      tcc_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_addr;
      end
      tcc_pkg::ST_EXEC: begin
        if (is_read) begin
          if (!in_range) begin
            done_next   = 1'b1;
            result_next = '{cell_value: 8'h00, cursor_col: cur_col5_x[4:0],
                            cursor_row: cur_row5_x[4:0], scrolled: 1'b0};
          end
        end else begin
          ram_we    = do_write;
          ram_wdata = req.char_code;
          if (!need_scroll) begin
            done_next   = 1'b1;
            result_next = '{cell_value: 8'h00, cursor_col: col_after5_x[4:0],
                            cursor_row: row_after5_x[4:0], scrolled: 1'b0};
          end
        end
      end
      tcc_pkg::ST_READ: begin
        done_next   = 1'b1;
        result_next = '{cell_value: ram_rdata, cursor_col: cur_col5_x[4:0],
                        cursor_row: cur_row5_x[4:0], scrolled: 1'b0};
      end
      tcc_pkg::ST_SCROLL: begin
        ram_we = 1'b1;
        if (clr_last) begin
          done_next   = 1'b1;
          result_next = '{cell_value: 8'h00, cursor_col: cur_col5_x[4:0],
                          cursor_row: cur_row5_x[4:0], scrolled: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Registers. The cursor is updated at the end of the execute cycle, so a scroll
  // result reports the cursor already placed on the last row.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcc_pkg::ST_INIT;
      init_addr <= '0;
      clr_col   <= '0;
      base      <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      done      <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= done_next;
      result <= result_next;
      if (state == tcc_pkg::ST_INIT) begin
        init_addr <= init_addr + 1'b1;
      end
      if (state == tcc_pkg::ST_IDLE && start) begin
        req <= request;
      end
      if (state == tcc_pkg::ST_EXEC && !is_read) begin
        cur_col <= col_after;
        cur_row <= row_after;
      end
      if (state == tcc_pkg::ST_SCROLL) begin
        clr_col <= clr_last ? '0 : clr_col + 1'b1;
        if (clr_last) begin
          base <= (base == LAST_ROW) ? '0 : base + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == tcc_pkg::ST_EXEC || $past(state) == tcc_pkg::ST_READ ||
              $past(state) == tcc_pkg::ST_SCROLL))
    else $error("result strobe without a finishing work step");
  a_cursor_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_row) < ROWS) && (int'(cur_col) < VISIBLE_COLS))
    else $error("cursor outside the visible area");
  a_base_in_bounds: assert property (@(posedge clk) disable iff (rst)
    int'(base) < ROWS)
    else $error("scroll base outside the row range");
  a_scroll_on_last_row: assert property (@(posedge clk) disable iff (rst)
    (done && result.scrolled) |-> (cur_row == LAST_ROW && cur_col == '0))
    else $error("scroll reported with cursor off the start of the last row");
  a_no_accept_during_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == tcc_pkg::ST_INIT) |=> (state == tcc_pkg::ST_INIT || state == tcc_pkg::ST_IDLE))
    else $error("map sweep left for a work state");
`endif

endmodule
